// ----- design/sfird_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfird_pkg
// Shared types and constants for the symmetric Q15 FIR decimator.
// ----------------------------------------------------------------------------
package sfird_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int CIDX_W    = 7;
    localparam int FRAC_BITS = 15;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic        [CIDX_W-1:0]   cidx_t;

    // item function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    // saturation limits of the output word
    localparam sample_t OUT_MAX = 16'sh7FFF;
    localparam sample_t OUT_MIN = 16'sh8000;

endpackage

// ----- design/sfird_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfird_ram
// Generic RAM: one write port, NUM_RD read ports, registered read data.
// ----------------------------------------------------------------------------
module sfird_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 128,
    parameter int NUM_RD = 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr [NUM_RD],
    output logic [WIDTH-1:0]         rd_data [NUM_RD]
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    for (genvar i = 0; i < NUM_RD; i++)
    begin : g_rd
        always_ff @(posedge clk)
        begin
            rd_data[i] <= mem[rd_addr[i]];
        end
    end

endmodule

// ----- design/symmetric_fir_decimator_q15_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_fir_decimator_q15_top
// Decimating linear-phase FIR, Q15, with one shared pre-add multiply-accumulate.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid / in_ready  | func, sample, coef_index, coef_value
//  out     | output    | out_valid / out_ready| out_sample
//
// A coefficient beat or a sample beat off the output phase is taken in ST_IDLE, which it does not leave.
// An output-phase sample starts a pass of the shared pre-add/multiply/accumulate
// pipe, which issues each coefficient in turn.
// The delay line needs no clearing pass: a fill count masks unwritten slots.
// in_ready is low from the MAC pass until the result is loaded into the output
// register (it waits in ST_DONE while that is full); then the next beat is taken.
// ----------------------------------------------------------------------------
module symmetric_fir_decimator_q15_top #(
    parameter int NUM_TAPS     = 253,
    parameter int DECIM_FACTOR = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  sfird_pkg::sample_t sample,
    input  sfird_pkg::cidx_t   coef_index,
    input  sfird_pkg::coef_t   coef_value,
    output logic               out_valid,
    input  logic               out_ready,
    output sfird_pkg::sample_t out_sample
);

    import sfird_pkg::*;

    localparam int NT       = NUM_TAPS;
    localparam int COEF_LEN = (NUM_TAPS + 1) / 2;
    localparam int DA_W     = $clog2(NT);
    localparam int CA_W     = $clog2(COEF_LEN);
    localparam int CNT_W    = $clog2(NT + 1);
    localparam int PH_W     = (DECIM_FACTOR > 1) ? $clog2(DECIM_FACTOR) : 1;
    localparam int TERM_W   = SAMPLE_W + 1;
    localparam int PROD_W   = TERM_W + COEF_W;
    localparam int ACC_W    = PROD_W + $clog2(COEF_LEN) + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [DA_W-1:0]  wp_reg, wp_next;
    logic [DA_W-1:0]  pa_reg, pa_next;
    logic [DA_W-1:0]  pb_reg, pb_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] thresh_reg, thresh_next;
    logic [CA_W-1:0]  k_reg, k_next;
    logic [PH_W-1:0]  phase_reg, phase_next;

    logic s1_v_reg, s1_va_reg, s1_vb_reg, s1_last_reg;
    logic s2_v_reg, s2_last_reg;
    logic s3_v_reg, s3_last_reg;

    logic signed [TERM_W-1:0] term_reg;
    coef_t                    coef_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic    out_valid_reg, out_valid_next;
    sample_t out_sample_reg, out_sample_next;

    logic in_fire, smp_fire, cf_fire, issue, out_load;

    logic [DA_W-1:0]     dl_rd_addr [2];
    logic [SAMPLE_W-1:0] dl_rd_data [2];
    logic [CA_W-1:0]     cf_rd_addr [1];
    logic [COEF_W-1:0]   cf_rd_data [1];

    logic [CNT_W-1:0]        k_ext, k_mirror;
    logic                    va, vb, pair, last_k;
    logic signed [TERM_W-1:0] term_a, term_b;
    logic signed [ACC_W-1:0] acc_sh;
    logic [ACC_W-FRAC_BITS-1:0] acc_hi;
    sample_t                 sat_val;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign smp_fire  = in_fire && (func == FUNC_SAMPLE);
    assign cf_fire   = in_fire && (func == FUNC_COEF) && (int'(coef_index) < COEF_LEN);
    assign issue     = (state_reg == ST_RUN);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // delay line: circular, depth NUM_TAPS, newest sample written before the pass
    assign dl_rd_addr[0] = pa_reg;
    assign dl_rd_addr[1] = pb_reg;

    sfird_ram #(
        .WIDTH  (SAMPLE_W),
        .DEPTH  (NT),
        .NUM_RD (2)
    ) u_dl_ram (
        .clk     (clk),
        .we      (smp_fire),
        .wr_addr (wp_reg),
        .wr_data (sample),
        .rd_addr (dl_rd_addr),
        .rd_data (dl_rd_data)
    );

    assign cf_rd_addr[0] = k_reg;

    sfird_ram #(
        .WIDTH  (COEF_W),
        .DEPTH  (COEF_LEN),
        .NUM_RD (1)
    ) u_cf_ram (
        .clk     (clk),
        .we      (cf_fire),
        .wr_addr (CA_W'(coef_index)),
        .wr_data (coef_value),
        .rd_addr (cf_rd_addr),
        .rd_data (cf_rd_data)
    );

    // tap flags: x[k] and x[NT-1-k] count only once written; centre tap unpaired
    always_comb
    begin
        k_ext    = CNT_W'(k_reg);
        k_mirror = CNT_W'(NT - 1) - k_ext;
        pair     = ({k_ext, 1'b0} != (CNT_W + 1)'(NT - 1));
        va       = (k_ext >= thresh_reg);
        vb       = (k_mirror >= thresh_reg) && pair;
        last_k   = (k_reg == CA_W'(COEF_LEN - 1));
    end

    assign term_a = s1_va_reg ? TERM_W'($signed(dl_rd_data[0])) : '0;
    assign term_b = s1_vb_reg ? TERM_W'($signed(dl_rd_data[1])) : '0;

    // shift by the Q15 fraction and saturate
    always_comb
    begin
        acc_sh = acc_reg >>> FRAC_BITS;
        acc_hi = acc_sh[ACC_W-1:FRAC_BITS];
        if ((&acc_hi) || !(|acc_hi))
        begin
            sat_val = acc_sh[SAMPLE_W-1:0];
        end
        else if (acc_sh[ACC_W-1])
        begin
            sat_val = OUT_MIN;
        end
        else
        begin
            sat_val = OUT_MAX;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        pa_next         = pa_reg;
        pb_next         = pb_reg;
        cnt_next        = cnt_reg;
        thresh_next     = thresh_reg;
        k_next          = k_reg;
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (s3_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (smp_fire)
                begin
                    wp_next     = (wp_reg == DA_W'(NT - 1)) ? '0 : wp_reg + 1'b1;
                    pa_next     = wp_next;
                    pb_next     = wp_reg;
                    cnt_next    = (cnt_reg == CNT_W'(NT)) ? cnt_reg : cnt_reg + 1'b1;
                    thresh_next = CNT_W'(NT) - cnt_next;
                    k_next      = '0;
                    acc_next    = '0;
                    phase_next  = (phase_reg == PH_W'(DECIM_FACTOR - 1)) ?
                                  '0 : phase_reg + 1'b1;
                    if (phase_reg == '0)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                pa_next = (pa_reg == DA_W'(NT - 1)) ? '0 : pa_reg + 1'b1;
                pb_next = (pb_reg == '0) ? DA_W'(NT - 1) : pb_reg - 1'b1;
                k_next  = k_reg + 1'b1;
                if (last_k)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s3_v_reg && s3_last_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sat_val;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            s1_v_reg      <= issue;
            s2_v_reg      <= s1_v_reg;
            s3_v_reg      <= s2_v_reg;
        end
    end

    // datapath: read -> pre-add -> multiply -> accumulate
    always_ff @(posedge clk)
    begin
        pa_reg         <= pa_next;
        pb_reg         <= pb_next;
        thresh_reg     <= thresh_next;
        k_reg          <= k_next;
        acc_reg        <= acc_next;
        out_sample_reg <= out_sample_next;
        s1_va_reg      <= va;
        s1_vb_reg      <= vb;
        s1_last_reg    <= issue && last_k;
        s2_last_reg    <= s1_last_reg;
        s3_last_reg    <= s2_last_reg;
        term_reg       <= term_a + term_b;
        coef_reg       <= $signed(cf_rd_data[0]);
        prod_reg       <= term_reg * coef_reg;
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(s1_v_reg || s2_v_reg || s3_v_reg))
        else $error("MAC pipe busy while taking beats");

    a_done_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !(s1_v_reg || s2_v_reg || s3_v_reg))
        else $error("result formed before last product summed");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NT))
        else $error("fill count beyond delay line depth");

    a_run_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg != '0) && (thresh_reg < CNT_W'(NT)))
        else $error("MAC pass without the new sample counted");

    a_load_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("output raised outside the result state");

endmodule

// ----- verif/symmetric_fir_decimator_q15_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_fir_decimator_q15_top_tb
// Self-checking bench for the decimate-by-3 symmetric Q15 FIR. A local
// predictor keeps its own delay line, half coefficient table and decimation
// count, and computes each output sample as input beats are accepted. Output
// beats are checked in order against the predicted samples while both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module symmetric_fir_decimator_q15_top_tb;

    import sfird_pkg::*;

    localparam int NUM_TAPS     = 253;
    localparam int DECIM_FACTOR = 3;
    localparam int HIST_LEN     = NUM_TAPS - 1;
    localparam int COEF_LEN     = (NUM_TAPS + 1) / 2;
    localparam int TOTAL_ITEMS  = 850;
    localparam int DRAIN_CYCLES = 300;
    localparam int LIMIT_CYCLES = 1_000_000;

    // coefficient table fill patterns
    localparam int FILL_RANDOM = 0;
    localparam int FILL_MAX    = 1;
    localparam int FILL_MIN    = 2;
    localparam int FILL_ALT    = 3;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_ready;
    logic    func       = FUNC_SAMPLE;
    sample_t sample     = '0;
    cidx_t   coef_index = '0;
    coef_t   coef_value = '0;
    logic    out_valid;
    logic    out_ready  = 1'b0;
    sample_t out_sample;

    // predictor state
    sample_t hist_samples [0:HIST_LEN-1];
    coef_t   coef_half    [0:COEF_LEN-1];
    int      decim_count;
    sample_t pending_out_samples [$];

    int  err_count   = 0;
    int  beats_sent  = 0;
    int  cycle_count = 0;
    bit  no_idle     = 1'b0;

    symmetric_fir_decimator_q15_top #(
        .NUM_TAPS     (NUM_TAPS),
        .DECIM_FACTOR (DECIM_FACTOR)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .sample     (sample),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return OUT_MAX;
        if (r < 10)
            return OUT_MIN;
        if (r < 35)
            return sample_t'(int'($urandom_range(0, 600)) - 300);
        return sample_t'($urandom_range(0, 16'hFFFF));
    endfunction

    // window = history plus newest sample; pairs share a coefficient
    function automatic sample_t decimated_sample(sample_t newest);
        sample_t win [0:NUM_TAPS-1];
        longint  acc;
        longint  term;
        longint  shifted;
        int      m;
        for (int i = 0; i < HIST_LEN; i++)
            win[i] = hist_samples[i];
        win[NUM_TAPS-1] = newest;
        acc = 0;
        for (int k = 0; k < COEF_LEN; k++)
        begin
            m = NUM_TAPS - 1 - k;
            if (m > k)
                term = longint'(win[k]) + longint'(win[m]);
            else if (m == k)
                term = longint'(win[k]);
            else
                break;
            acc += term * longint'(coef_half[k]);
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > longint'(OUT_MAX))
            return OUT_MAX;
        if (shifted < longint'(OUT_MIN))
            return OUT_MIN;
        return sample_t'(shifted);
    endfunction

    task automatic absorb_beat(logic f, sample_t s, cidx_t idx, coef_t v);
        if (f == FUNC_COEF)
        begin
            if (idx < COEF_LEN)
                coef_half[idx] = v;
        end
        else
        begin
            if (decim_count == 0)
                pending_out_samples.push_back(decimated_sample(s));
            for (int i = 0; i < HIST_LEN - 1; i++)
                hist_samples[i] = hist_samples[i+1];
            hist_samples[HIST_LEN-1] = s;
            decim_count = (decim_count + 1) % DECIM_FACTOR;
        end
    endtask

    // valid is only lowered when a gap follows, so back-to-back beats keep it high
    task automatic send_beat(logic f, sample_t s, cidx_t idx, coef_t v);
        int gap;
        gap = pick_gap(no_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        sample     <= s;
        coef_index <= idx;
        coef_value <= v;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_beat(f, s, idx, v);
        beats_sent++;
    endtask

    // unused payload fields carry random junk
    task automatic send_sample(sample_t s);
        send_beat(FUNC_SAMPLE, s, cidx_t'($urandom_range(0, 127)),
                  coef_t'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic send_coef(cidx_t idx, coef_t v);
        send_beat(FUNC_COEF, sample_t'($urandom_range(0, 16'hFFFF)), idx, v);
    endtask

    task automatic load_coef_table(int fill);
        coef_t v;
        for (int k = 0; k < COEF_LEN; k++)
        begin
            case (fill)
                FILL_MAX: v = OUT_MAX;
                FILL_MIN: v = OUT_MIN;
                FILL_ALT: v = (k % 2 == 0) ? OUT_MAX : OUT_MIN;
                default:  v = coef_t'($urandom_range(0, 16'hFFFF));
            endcase
            send_coef(cidx_t'(k), v);
        end
    endtask

    task automatic test_coef_load();
        load_coef_table(FILL_RANDOM);
        send_coef(cidx_t'(0), OUT_MIN);
        send_coef(cidx_t'(COEF_LEN - 1), OUT_MAX);
    endtask

    // first sample after reset sees a zeroed delay line
    task automatic test_first_window();
        send_sample(OUT_MAX);
        send_sample(OUT_MIN);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sh5555);
        send_sample(sample_t'(16'hAAAA));
        send_sample(16'sd12345);
    endtask

    // coef beats land on every decimation phase; index 127 must be dropped
    task automatic test_coef_midstream();
        send_coef(cidx_t'(127), OUT_MAX);
        send_sample(pick_sample());
        send_coef(cidx_t'(5), coef_t'(-16'sd1234));
        send_sample(pick_sample());
        send_coef(cidx_t'(127), OUT_MIN);
        send_sample(pick_sample());
        send_coef(cidx_t'(COEF_LEN - 1), coef_t'(16'sd20000));
        send_sample(pick_sample());
    endtask

    task automatic test_saturation();
        load_coef_table(FILL_MAX);
        repeat (6) send_sample(OUT_MAX);
        repeat (12) send_sample(OUT_MIN);
        load_coef_table(FILL_RANDOM);
    endtask

    task automatic test_random();
        int r;
        int run;
        while (beats_sent < TOTAL_ITEMS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                run = $urandom_range(3, 30);
                repeat (run) send_sample(pick_sample());
            end
            else if (r < 92)
            begin
                run = $urandom_range(1, 4);
                repeat (run)
                    send_coef(cidx_t'($urandom_range(0, COEF_LEN - 1)),
                              ($urandom_range(0, 9) == 0) ? OUT_MIN
                                                          : coef_t'($urandom_range(0, 16'hFFFF)));
            end
            else if (r < 98)
                send_coef(cidx_t'(127), coef_t'($urandom_range(0, 16'hFFFF)));
            else
                load_coef_table($urandom_range(FILL_RANDOM, FILL_ALT));
        end
        no_idle = 1'b0;
    endtask

    // output side backpressure
    initial
    begin
        int stall;
        forever
        begin
            stall = pick_gap(1'b0);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_out_samples.size() == 0)
            begin
                $error("out_sample: unexpected beat, got %0d", out_sample);
                err_count++;
            end
            else
            begin
                if (out_sample !== pending_out_samples[0])
                begin
                    $error("out_sample mismatch: expected %0d, got %0d",
                           pending_out_samples[0], out_sample);
                    err_count++;
                end
                void'(pending_out_samples.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("[symmetric_fir_decimator_q15_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < HIST_LEN; i++)
            hist_samples[i] = '0;
        for (int k = 0; k < COEF_LEN; k++)
            coef_half[k] = '0;
        decim_count = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_coef_load();
        test_first_window();
        test_coef_midstream();
        test_saturation();
        test_random();
        in_valid <= 1'b0;

        while (pending_out_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_out_samples.size() != 0)
        begin
            $error("out_sample: %0d expected beats never arrived",
                   pending_out_samples.size());
            err_count++;
        end

        if (err_count == 0)
            $display("[symmetric_fir_decimator_q15_top] OK");
        else
            $display("[symmetric_fir_decimator_q15_top] ERROR");
        $finish;
    end

endmodule
